### hw/rtl/ubp_pkg.sv
// Shared types and constants for the UART ring buffer pair.
`default_nettype none

package ubp_pkg;

  localparam logic [7:0] NEWLINE  = 8'h0A;
  localparam logic [7:0] BYTE_MAX = 8'hFF;

  typedef enum logic [2:0] {
    OP_LINE_RX    = 3'd0,
    OP_READ_BYTE  = 3'd1,
    OP_READ_LINE  = 3'd2,
    OP_WRITE_BYTE = 3'd3,
    OP_TX_READY   = 3'd4,
    OP_TX_DONE    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_RX   = 2'd1,
    KIND_TX   = 2'd2,
    KIND_DONE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_LINE_RD,
    ST_OUT
  } state_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last;
    logic [7:0] rx_count;
    logic       tx_irq_on;
    logic       tc_irq_on;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/uart_ring_buffer_pair.sv
// Top level of the UART receive/transmit ring buffer pair.
// Every single-result beat on the input takes at most one synchronous memory
// access: it is accepted in the idle state and its result is ready in the next
// cycle. A line read scans the receive memory byte by byte through the SCAN_RD
// and SCAN_CHK states to find its end, then rereads each byte in LINE_RD and
// emits it from OUT, since the receive memory has a registered read port. The
// output register lets the next input beat be taken while a result still waits
// downstream. No clearing pass follows reset; the rings are ready at once.
`default_nettype none

module uart_ring_buffer_pair #(
  parameter int unsigned RING_DEPTH = 256,
  parameter int unsigned MAX_LINE   = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // op[2:0], data_byte[10:3], max_len[17:11]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata,  // out_byte[7:0], has_byte[8], rx_count[16:9],
                                          // tx_irq_on[17], tc_irq_on[18]
  output logic      [1:0]  m_axis_tuser,  // kind[1:0]
  output logic             m_axis_tlast
);

  localparam int unsigned PW = $clog2(RING_DEPTH);

  logic          res_valid, res_ready;
  ubp_pkg::res_t res, m_res_q;
  logic          m_valid_q;

  logic          rx_we, rx_re, tx_we, tx_re;
  logic [PW-1:0] rx_waddr, rx_raddr, tx_waddr, tx_raddr;
  logic [7:0]    rx_wdata, rx_rdata, tx_wdata, tx_rdata;

  ubp_ring #(.RING_DEPTH(RING_DEPTH)) u_rx_ring (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_waddr),
    .wdata_i (rx_wdata),
    .re_i    (rx_re),
    .raddr_i (rx_raddr),
    .rdata_o (rx_rdata)
  );

  ubp_ring #(.RING_DEPTH(RING_DEPTH)) u_tx_ring (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_waddr),
    .wdata_i (tx_wdata),
    .re_i    (tx_re),
    .raddr_i (tx_raddr),
    .rdata_o (tx_rdata)
  );

  ubp_ctrl #(.RING_DEPTH(RING_DEPTH), .MAX_LINE(MAX_LINE)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (ubp_pkg::op_e'(s_axis_tdata[2:0])),
    .in_byte_i   (s_axis_tdata[10:3]),
    .in_len_i    (s_axis_tdata[17:11]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .rx_we_o     (rx_we),
    .rx_waddr_o  (rx_waddr),
    .rx_wdata_o  (rx_wdata),
    .rx_re_o     (rx_re),
    .rx_raddr_o  (rx_raddr),
    .rx_rdata_i  (rx_rdata),
    .tx_we_o     (tx_we),
    .tx_waddr_o  (tx_waddr),
    .tx_wdata_o  (tx_wdata),
    .tx_re_o     (tx_re),
    .tx_raddr_o  (tx_raddr),
    .tx_rdata_i  (tx_rdata)
  );

  assign res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_res_q.kind;
  assign m_axis_tlast  = m_res_q.last;
  assign m_axis_tdata  = {5'b0, m_res_q.tc_irq_on, m_res_q.tx_irq_on, m_res_q.rx_count,
                          m_res_q.has_byte, m_res_q.out_byte};

endmodule

`default_nettype wire

### hw/rtl/ubp_ring.sv
// Byte-wide ring storage: one write port, one registered read port.
`default_nettype none

module ubp_ring #(
  parameter int unsigned RING_DEPTH = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [$clog2(RING_DEPTH)-1:0] waddr_i,
  input  wire logic [7:0]                    wdata_i,
  input  wire logic                          re_i,
  input  wire logic [$clog2(RING_DEPTH)-1:0] raddr_i,
  output logic      [7:0]                    rdata_o
);

  logic [7:0] mem_q [RING_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/ubp_ctrl.sv
// Ring pointers, interrupt enables and the operation sequencer.
`default_nettype none

module ubp_ctrl #(
  parameter int unsigned RING_DEPTH = 256,
  parameter int unsigned MAX_LINE   = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire ubp_pkg::op_e                  in_op_i,
  input  wire logic [7:0]                    in_byte_i,
  input  wire logic [6:0]                    in_len_i,
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output ubp_pkg::res_t                      res_o,
  output logic                               rx_we_o,
  output logic      [$clog2(RING_DEPTH)-1:0] rx_waddr_o,
  output logic      [7:0]                    rx_wdata_o,
  output logic                               rx_re_o,
  output logic      [$clog2(RING_DEPTH)-1:0] rx_raddr_o,
  input  wire logic [7:0]                    rx_rdata_i,
  output logic                               tx_we_o,
  output logic      [$clog2(RING_DEPTH)-1:0] tx_waddr_o,
  output logic      [7:0]                    tx_wdata_o,
  output logic                               tx_re_o,
  output logic      [$clog2(RING_DEPTH)-1:0] tx_raddr_o,
  input  wire logic [7:0]                    tx_rdata_i
);

  localparam int unsigned PW = $clog2(RING_DEPTH);
  localparam int unsigned LW = $clog2(MAX_LINE);

  ubp_pkg::state_e state_q, state_d;
  logic [PW-1:0]   rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [PW-1:0]   tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic            tx_en_q, tx_en_d, tc_en_q, tc_en_d;
  logic [PW-1:0]   ptr_q, ptr_d;
  logic [LW-1:0]   cnt_q, cnt_d, limit_q, limit_d;
  ubp_pkg::kind_e  kind_q, kind_d;
  logic            has_q, has_d;

  logic [PW-1:0] rx_nxt, tx_nxt, ptr_nx, rx_fill;
  logic          rx_full, rx_empty, tx_full, tx_empty;
  logic [6:0]    len_c;
  logic [LW-1:0] limit_in, taken_nx;
  logic          line_go, scan_stop;

  assign rx_nxt   = rx_head_q + PW'(1);
  assign tx_nxt   = tx_head_q + PW'(1);
  assign rx_full  = (rx_nxt == rx_tail_q);
  assign tx_full  = (tx_nxt == tx_tail_q);
  assign rx_empty = (rx_head_q == rx_tail_q);
  assign tx_empty = (tx_head_q == tx_tail_q);
  assign rx_fill  = rx_head_q - rx_tail_q;

  assign len_c    = (in_len_i > 7'(MAX_LINE)) ? 7'(MAX_LINE) : in_len_i;
  assign limit_in = (len_c == 7'd0) ? '0 : LW'(len_c - 7'd1);
  assign line_go  = (in_op_i == ubp_pkg::OP_READ_LINE) && !rx_empty && (limit_in != '0);

  assign ptr_nx    = ptr_q + PW'(1);
  assign taken_nx  = cnt_q + LW'(1);
  assign scan_stop = (rx_rdata_i == ubp_pkg::NEWLINE) || (taken_nx == limit_q) ||
                     (ptr_nx == rx_head_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ubp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = line_go ? ubp_pkg::ST_SCAN_RD : ubp_pkg::ST_OUT;
        end
      end
      ubp_pkg::ST_SCAN_RD:  state_d = ubp_pkg::ST_SCAN_CHK;
      ubp_pkg::ST_SCAN_CHK: state_d = scan_stop ? ubp_pkg::ST_LINE_RD : ubp_pkg::ST_SCAN_RD;
      ubp_pkg::ST_LINE_RD:  state_d = ubp_pkg::ST_OUT;
      ubp_pkg::ST_OUT: begin
        if (res_ready_i) begin
          state_d = (cnt_q == LW'(1)) ? ubp_pkg::ST_IDLE : ubp_pkg::ST_LINE_RD;
        end
      end
      default: state_d = ubp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rx_head_d  = rx_head_q;
    rx_tail_d  = rx_tail_q;
    tx_head_d  = tx_head_q;
    tx_tail_d  = tx_tail_q;
    tx_en_d    = tx_en_q;
    tc_en_d    = tc_en_q;
    ptr_d      = ptr_q;
    cnt_d      = cnt_q;
    limit_d    = limit_q;
    kind_d     = kind_q;
    has_d      = has_q;
    rx_we_o    = 1'b0;
    rx_waddr_o = rx_head_q;
    rx_wdata_o = in_byte_i;
    rx_re_o    = 1'b0;
    rx_raddr_o = rx_tail_q;
    tx_we_o    = 1'b0;
    tx_waddr_o = tx_head_q;
    tx_wdata_o = in_byte_i;
    tx_re_o    = 1'b0;
    tx_raddr_o = tx_tail_q;
    case (state_q)
      ubp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cnt_d  = LW'(1);
          has_d  = 1'b0;
          kind_d = ubp_pkg::KIND_ACK;
          case (in_op_i)
            ubp_pkg::OP_LINE_RX: begin
              if (!rx_full) begin
                rx_we_o   = 1'b1;
                rx_head_d = rx_nxt;
              end
            end
            ubp_pkg::OP_READ_BYTE: begin
              kind_d = ubp_pkg::KIND_RX;
              if (!rx_empty) begin
                rx_re_o   = 1'b1;
                rx_tail_d = rx_tail_q + PW'(1);
                has_d     = 1'b1;
              end
            end
            ubp_pkg::OP_READ_LINE: begin
              kind_d = ubp_pkg::KIND_RX;
              if (line_go) begin
                ptr_d   = rx_tail_q;
                cnt_d   = '0;
                limit_d = limit_in;
              end
            end
            ubp_pkg::OP_WRITE_BYTE: begin
              if (!tx_full) begin
                tx_we_o   = 1'b1;
                tx_head_d = tx_nxt;
                tx_en_d   = 1'b1;
              end
            end
            ubp_pkg::OP_TX_READY: begin
              if (tx_en_q) begin
                if (!tx_empty) begin
                  kind_d    = ubp_pkg::KIND_TX;
                  has_d     = 1'b1;
                  tx_re_o   = 1'b1;
                  tx_tail_d = tx_tail_q + PW'(1);
                end else begin
                  tx_en_d = 1'b0;
                  tc_en_d = 1'b1;
                end
              end
            end
            ubp_pkg::OP_TX_DONE: begin
              if (tc_en_q) begin
                tc_en_d = 1'b0;
                kind_d  = ubp_pkg::KIND_DONE;
              end
            end
            default: ;
          endcase
        end
      end
      ubp_pkg::ST_SCAN_RD: begin
        rx_re_o    = 1'b1;
        rx_raddr_o = ptr_q;
      end
      ubp_pkg::ST_SCAN_CHK: begin
        cnt_d = taken_nx;
        if (scan_stop) begin
          // rewind to the old tail for emission, commit the new tail now
          ptr_d     = rx_tail_q;
          rx_tail_d = ptr_nx;
          has_d     = 1'b1;
        end else begin
          ptr_d = ptr_nx;
        end
      end
      ubp_pkg::ST_LINE_RD: begin
        rx_re_o    = 1'b1;
        rx_raddr_o = ptr_q;
        ptr_d      = ptr_nx;
      end
      ubp_pkg::ST_OUT: begin
        if (res_ready_i) begin
          cnt_d = cnt_q - LW'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    in_ready_o      = (state_q == ubp_pkg::ST_IDLE);
    res_valid_o     = (state_q == ubp_pkg::ST_OUT);
    res_o.kind      = kind_q;
    res_o.has_byte  = has_q;
    res_o.out_byte  = !has_q ? 8'h00 :
                      (kind_q == ubp_pkg::KIND_TX) ? tx_rdata_i : rx_rdata_i;
    res_o.last      = (cnt_q == LW'(1));
    res_o.rx_count  = (rx_fill > PW'(255)) ? ubp_pkg::BYTE_MAX : 8'(rx_fill);
    res_o.tx_irq_on = tx_en_q;
    res_o.tc_irq_on = tc_en_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ubp_pkg::ST_IDLE;
      rx_head_q <= '0;
      rx_tail_q <= '0;
      tx_head_q <= '0;
      tx_tail_q <= '0;
      tx_en_q   <= 1'b0;
      tc_en_q   <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      rx_head_q <= rx_head_d;
      rx_tail_q <= rx_tail_d;
      tx_head_q <= tx_head_d;
      tx_tail_q <= tx_tail_d;
      tx_en_q   <= tx_en_d;
      tc_en_q   <= tc_en_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q   <= ptr_d;
    limit_q <= limit_d;
    kind_q  <= kind_d;
    has_q   <= has_d;
  end

endmodule

`default_nettype wire

### hw/rtl/ubp_checker.sv
// Port-level checks for the UART ring buffer pair, bound to the top level.
`default_nettype none

module ubp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  logic in_go;

  assign in_go = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  a_ack_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ubp_pkg::KIND_ACK) |->
      m_axis_tlast && !m_axis_tdata[8] && (m_axis_tdata[7:0] == 8'h00))
    else $error("acknowledge beat carries a byte");

  a_done_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ubp_pkg::KIND_DONE) |->
      m_axis_tlast && !m_axis_tdata[18] && !m_axis_tdata[8])
    else $error("transmit done beat with complete enable still set");

  a_tx_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ubp_pkg::KIND_TX) |->
      m_axis_tlast && m_axis_tdata[8] && m_axis_tdata[17])
    else $error("transmit beat without byte or enable");

  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_go |=> !s_axis_tready)
    else $error("input beat taken while the previous one is in flight");

endmodule

bind uart_ring_buffer_pair ubp_checker u_ubp_checker (.*);

`default_nettype wire
